### sv/stdf_pkg.sv
// ----------------------------------------------------------------------------
// stdf_pkg
// Shared types and constants for the sample triplet decimal formatter.
// ----------------------------------------------------------------------------
package stdf_pkg;

   // width of the scaled place value; 8 * 1000 fits in 13 bits
   localparam int MULT_W = 13;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;

   // index of the last sample in a set
   localparam logic [1:0] LAST_SEL = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_CALC = 5'b00010,
      ST_PUT  = 5'b00100,
      ST_SEP1 = 5'b01000,
      ST_SEP2 = 5'b10000
   } state_type;

   // place value (1000, 100, 10, 1 for place 3..0) times 2**step
   function automatic logic [MULT_W-1:0] place_mult(input logic [1:0] place,
                                                    input logic [1:0] step);
      logic [MULT_W-1:0] base;
      unique case (place)
         2'd3: base = MULT_W'(1000);
         2'd2: base = MULT_W'(100);
         2'd1: base = MULT_W'(10);
         2'd0: base = MULT_W'(1);
         default: base = '0;
      endcase
      return base << step;
   endfunction

endpackage

### sv/sample_triplet_decimal_formatter.sv
// ----------------------------------------------------------------------------
// sample_triplet_decimal_formatter
// Formats three converter samples as the ASCII line "a, b, c" CR LF.
// ----------------------------------------------------------------------------
// One request transaction carries a potentiometer, a light sensor and a
// thermistor sample. The block answers with one response transaction per
// character of the line "a, b, c\r\n": each value in decimal without leading
// zeros (zero prints as a single '0'), comma and space between values, and
// rsp_last high on the closing LF. Digits come from one shared
// compare-and-subtract unit that tests the remainder against 8x, 4x, 2x and
// 1x the current place value (1000, 100, 10, 1) in ST_CALC, one multiple at
// a time, after which ST_PUT hands any digit that prints to the output register.
// Each sample then ends with its two separator characters from ST_SEP1 and
// ST_SEP2. While the response side stalls, ST_SEP1, ST_SEP2 and ST_PUT with a
// digit to print wait until the output register is free again.
// req_stall stays high from acceptance until the LF has been loaded into the
// output register, after which the next set is taken while LF still waits.
// ----------------------------------------------------------------------------
module sample_triplet_decimal_formatter #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SAMPLE_BITS-1:0] req_pot_sample,
   input  logic [SAMPLE_BITS-1:0] req_light_sample,
   input  logic [SAMPLE_BITS-1:0] req_thermistor_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_char_out,
   output logic                   rsp_last
);
   import stdf_pkg::*;

   // sequencer
   state_type state_ff, state_in;

   // captured samples; entry 0 is loaded straight into the remainder
   logic [SAMPLE_BITS-1:0] samples_ff [0:2];
   logic [SAMPLE_BITS-1:0] samples_in [0:2];

   logic [1:0]             sel_ff, sel_in;          // which sample
   logic [SAMPLE_BITS-1:0] val_ff, val_in;          // remainder
   logic [1:0]             place_ff, place_in;      // decimal place 3..0
   logic [1:0]             step_ff, step_in;        // multiple 8,4,2,1
   logic [3:0]             digit_ff, digit_in;
   logic                   started_ff, started_in;  // nonzero digit seen

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_char_ff, rsp_char_in;
   logic       rsp_last_ff, rsp_last_in;

   // shared compare-and-subtract unit
   logic [MULT_W-1:0] mult;
   logic [MULT_W-1:0] val_ext;
   logic              ge;
   logic [MULT_W-1:0] diff;

   logic out_free;
   logic accept;
   logic emit;
   logic last_sample;

   assign mult    = place_mult(place_ff, step_ff);
   assign val_ext = MULT_W'(val_ff);
   assign ge      = val_ext >= mult;
   assign diff    = val_ext - mult;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign accept      = req_valid && (state_ff == ST_IDLE);
   assign last_sample = (sel_ff == LAST_SEL);
   // leading zeros are dropped, but the units place always prints
   assign emit        = (digit_ff != 4'd0) || started_ff || (place_ff == 2'd0);

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_char_out = rsp_char_ff;
   assign rsp_last     = rsp_last_ff;

   always_comb begin
      state_in     = state_ff;
      samples_in   = samples_ff;
      sel_in       = sel_ff;
      val_in       = val_ff;
      place_in     = place_ff;
      step_in      = step_ff;
      digit_in     = digit_ff;
      started_in   = started_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               samples_in[0] = req_pot_sample;
               samples_in[1] = req_light_sample;
               samples_in[2] = req_thermistor_sample;
               sel_in        = 2'd0;
               val_in        = req_pot_sample;
               place_in      = 2'd3;
               step_in       = 2'd3;
               digit_in      = 4'd0;
               started_in    = 1'b0;
               state_in      = ST_CALC;
            end
         end

         ST_CALC: begin
            if (ge) begin
               val_in   = diff[SAMPLE_BITS-1:0];
               digit_in = digit_ff | (4'd1 << step_ff);
            end
            if (step_ff == 2'd0) begin
               state_in = ST_PUT;
            end else begin
               step_in = step_ff - 2'd1;
            end
         end

         ST_PUT: begin
            if (!emit || out_free) begin
               if (emit) begin
                  rsp_valid_in = 1'b1;
                  rsp_char_in  = CHAR_ZERO + {4'd0, digit_ff};
                  rsp_last_in  = 1'b0;
                  started_in   = 1'b1;
               end
               step_in  = 2'd3;
               digit_in = 4'd0;
               if (place_ff == 2'd0) begin
                  state_in = ST_SEP1;
               end else begin
                  place_in = place_ff - 2'd1;
                  state_in = ST_CALC;
               end
            end
         end

         ST_SEP1: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = last_sample ? CHAR_CR : CHAR_COMMA;
               rsp_last_in  = 1'b0;
               state_in     = ST_SEP2;
            end
         end

         ST_SEP2: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = last_sample ? CHAR_LF : CHAR_SPACE;
               rsp_last_in  = last_sample;
               if (last_sample) begin
                  state_in = ST_IDLE;
               end else begin
                  sel_in     = sel_ff + 2'd1;
                  val_in     = samples_ff[sel_ff + 2'd1];
                  place_in   = 2'd3;
                  step_in    = 2'd3;
                  digit_in   = 4'd0;
                  started_in = 1'b0;
                  state_in   = ST_CALC;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      samples_ff  <= samples_in;
      sel_ff      <= sel_in;
      val_ff      <= val_in;
      place_ff    <= place_in;
      step_ff     <= step_in;
      digit_ff    <= digit_in;
      started_ff  <= started_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------

   // end-of-line flag only ever rides on LF
   a_last_is_lf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_char_ff == CHAR_LF)
      else $error("last flag on a character other than LF");

   // a finished digit is a decimal digit
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PUT |-> digit_ff <= 4'd9)
      else $error("digit out of range");

   // an accepted set starts digit work in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == ST_CALC && sel_ff == 2'd0)
      else $error("accepted set did not start conversion");

   // a stalled response is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_char_ff))
      else $error("pending character overwritten");

endmodule

### verif/csv_line_checker.sv
// ----------------------------------------------------------------------------
// csv_line_checker
// Predicts and checks the ASCII line produced for each accepted sample set.
// ----------------------------------------------------------------------------
// Every accepted request transaction is turned into the characters of
// "a, b, c" CR LF and queued. Each accepted response transaction is compared
// field by field against the oldest queued character.
// ----------------------------------------------------------------------------
module csv_line_checker #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [SAMPLE_BITS-1:0] req_pot_sample,
   input  logic [SAMPLE_BITS-1:0] req_light_sample,
   input  logic [SAMPLE_BITS-1:0] req_thermistor_sample,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [7:0]             rsp_char_out,
   input  logic                   rsp_last,
   output int                     fail_count,
   output int                     chars_pending
);
   import stdf_pkg::*;

   // values past four digits clamp here
   localparam int unsigned DIGIT_CAP = 9999;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } line_char_type;

   line_char_type expected_chars[$];

   function automatic void push_char(input logic [7:0] ch, input logic is_last);
      line_char_type c;
      c.ch   = ch;
      c.last = is_last;
      expected_chars.push_back(c);
   endfunction

   function automatic void push_decimal(input logic [SAMPLE_BITS-1:0] sample);
      int unsigned v;
      int unsigned digits[4];
      int          n;
      v = sample;
      n = 0;
      if (v > DIGIT_CAP) v = DIGIT_CAP;
      if (v == 0) begin
         push_char(CHAR_ZERO, 1'b0);
      end else begin
         while (v != 0 && n < 4) begin
            digits[n] = v % 10;
            v = v / 10;
            n++;
         end
         while (n > 0) begin
            n--;
            push_char(CHAR_ZERO + 8'(digits[n]), 1'b0);
         end
      end
   endfunction

   function automatic void predict_line(input logic [SAMPLE_BITS-1:0] pot,
                                        input logic [SAMPLE_BITS-1:0] light,
                                        input logic [SAMPLE_BITS-1:0] therm);
      push_decimal(pot);
      push_char(CHAR_COMMA, 1'b0);
      push_char(CHAR_SPACE, 1'b0);
      push_decimal(light);
      push_char(CHAR_COMMA, 1'b0);
      push_char(CHAR_SPACE, 1'b0);
      push_decimal(therm);
      push_char(CHAR_CR, 1'b0);
      push_char(CHAR_LF, 1'b1);
   endfunction

   always @(posedge clock) begin
      line_char_type want;
      if (reset) begin
         expected_chars.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_chars.size() == 0) begin
               $display("%0t: unexpected character, expected none, actual 8'h%02h last %0b",
                        $time, rsp_char_out, rsp_last);
               fail_count++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_char_out !== want.ch) begin
                  $display("%0t: char_out mismatch, expected 8'h%02h, actual 8'h%02h",
                           $time, want.ch, rsp_char_out);
                  fail_count++;
               end
               if (rsp_last !== want.last) begin
                  $display("%0t: last mismatch, expected %0b, actual %0b",
                           $time, want.last, rsp_last);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            predict_line(req_pot_sample, req_light_sample, req_thermistor_sample);
      end
      chars_pending = expected_chars.size();
   end

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the sample triplet decimal formatter.
// ----------------------------------------------------------------------------
// Drives sample sets into the formatter and lets csv_line_checker predict and
// compare every character of each "a, b, c" CR LF line. A short directed run
// covers zero, full scale, all digit counts on pot and thermistor, alternating
// bit patterns; random sets follow under several idling mixes, a long response
// hold-off that backs the block up, and pauses that let the output drain.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int SAMPLE_BITS    = 10;
   localparam int SAMPLE_MAX     = (1 << SAMPLE_BITS) - 1;
   // response side held off this long once, with the sender still pushing
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 100;
   // cycles with no transaction on either channel before giving up
   localparam int WATCHDOG_LIMIT = 2000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [SAMPLE_BITS-1:0] req_pot_sample = '0;
   logic [SAMPLE_BITS-1:0] req_light_sample = '0;
   logic [SAMPLE_BITS-1:0] req_thermistor_sample = '0;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [7:0]             rsp_char_out;
   logic                   rsp_last;

   int fail_count;
   int chars_pending;
   int idle_cycles = 0;

   // idling mix, percent of cycles; read by the driver and the receiver
   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   // set by the stimulus, cleared by the receiver once the hold-off is over
   bit hold_rsp = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   sample_triplet_decimal_formatter #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_pot_sample       (req_pot_sample),
      .req_light_sample     (req_light_sample),
      .req_thermistor_sample(req_thermistor_sample),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_char_out         (rsp_char_out),
      .rsp_last             (rsp_last)
   );

   csv_line_checker #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_pot_sample       (req_pot_sample),
      .req_light_sample     (req_light_sample),
      .req_thermistor_sample(req_thermistor_sample),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_char_out         (rsp_char_out),
      .rsp_last             (rsp_last),
      .fail_count           (fail_count),
      .chars_pending        (chars_pending)
   );

   // Receiver: random stall at each falling edge, or one long hold-off on
   // request. At most one stall update per falling edge.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Watchdog: any transaction on either side resets the count.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired, %0d characters still pending",
                  $time, chars_pending);
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Called just after a falling edge; returns just after the falling edge
   // that follows acceptance. Valid stays high into the next set when there
   // is no gap, so it is never dropped and raised in the same step.
   task automatic send_set(input logic [SAMPLE_BITS-1:0] pot,
                           input logic [SAMPLE_BITS-1:0] light,
                           input logic [SAMPLE_BITS-1:0] therm);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid             <= 1'b1;
      req_pot_sample        <= pot;
      req_light_sample      <= light;
      req_thermistor_sample <= therm;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Even spread over digit counts so short and long numbers both show up.
   function automatic logic [SAMPLE_BITS-1:0] random_sample();
      int unsigned lo;
      int unsigned hi;
      case ($urandom_range(3))
         0: begin lo = 0;    hi = 9;    end
         1: begin lo = 10;   hi = 99;   end
         2: begin lo = 100;  hi = 999;  end
         default: begin lo = 1000; hi = 9999; end
      endcase
      if (hi > SAMPLE_MAX) hi = SAMPLE_MAX;
      if (lo > hi) lo = 0;
      return SAMPLE_BITS'($urandom_range(hi, lo));
   endfunction

   task automatic send_random_sets(input int count);
      repeat (count) send_set(random_sample(), random_sample(), random_sample());
   endtask

   // Sender pause: valid low until every expected character has come out.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (chars_pending != 0) @(negedge clock);
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: zero, full scale, one to four digits on pot and thermistor,
      // alternating bit patterns.
      send_set('0, '0, '0);
      send_set(SAMPLE_BITS'(SAMPLE_MAX), SAMPLE_BITS'(SAMPLE_MAX),
               SAMPLE_BITS'(SAMPLE_MAX));
      send_set(10'd1, 10'd9, 10'd10);
      send_set(10'd99, 10'd100, 10'd999);
      send_set(10'd1000, 10'd1001, 10'd512);
      send_set(10'd1023, 10'd0, 10'd7);
      send_set(10'd0, 10'd1, 10'd1022);
      send_set(10'd10, 10'd100, 10'd1000);
      send_set(10'd341, 10'd682, 10'd5);
      send_set(10'd682, 10'd341, 10'd0);
      send_set(10'd86, 10'd1019, 10'd40);
      send_set(10'd5, 10'd0, 10'd1010);

      // No idling on either side.
      send_random_sets(90);
      wait_drained();

      // Sender idle most of the time.
      req_idle_pct  = 78;
      rsp_stall_pct = 0;
      send_random_sets(90);

      // Receiver stalling most of the time.
      req_idle_pct  = 0;
      rsp_stall_pct = 78;
      send_random_sets(90);
      wait_drained();

      // Both sides idling now and then.
      req_idle_pct  = 37;
      rsp_stall_pct = 37;
      send_random_sets(90);

      // Long response hold-off with the sender pushing: the block fills
      // and holds off its request side until the receiver lets go.
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      hold_rsp      = 1'b1;
      send_random_sets(20);
      wait_drained();

      // Closing stretch with no idling at all.
      send_random_sets(60);

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
